>>> design/masked_byte_pattern_scanner_assert.svh
// Assertion macros used by the scanner core.
// Each macro checks on the rising edge of i_clk and is off while reset is held.
`ifndef MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

    localparam int BYTE_W            = 8;
    localparam int MAX_PATTERN_BYTES = 16;
    localparam int MAX_REGION_BYTES  = 65536;
    localparam int LEN_W             = 5;
    localparam int EFF_W             = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W             = $clog2(MAX_PATTERN_BYTES);
    localparam int COUNT_W           = $clog2(MAX_REGION_BYTES + 1);
    localparam int OFFSET_W          = 16;
    localparam int MASK_W            = 16;
    localparam int HALF_BYTES        = 8;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;

    localparam logic [MASK_W-1:0] MASK_RESET   = '1;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = LEN_W'(1);
    localparam logic [BYTE_W-1:0] KEY_RESET    = 8'h00;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW  = 3'd0,
        CFG_PATTERN_HIGH = 3'd1,
        CFG_COMPARE_MASK = 3'd2,
        CFG_PATTERN_LEN  = 3'd3,
        CFG_XOR_KEY      = 3'd4
    } t_cfg_index;

    // Settings as the compare logic sees them: keyed pattern bytes,
    // compare mask and the clamped pattern length.
    typedef struct packed {
        logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] want;
        logic [MASK_W-1:0]                        mask;
        logic [EFF_W-1:0]                         eff_len;
    } t_cfg;

    typedef struct packed {
        logic                valid;
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } t_result;

endpackage

`default_nettype wire

>>> design/mbps_cfg.sv
`default_nettype none

module mbps_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [mbps_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    output mbps_pkg::t_cfg                          o_cfg
);

    logic [mbps_pkg::CFG_DATA_W-1:0] r_pattern_low;
    logic [mbps_pkg::CFG_DATA_W-1:0] r_pattern_high;
    logic [mbps_pkg::MASK_W-1:0]     r_mask;
    logic [mbps_pkg::LEN_W-1:0]      r_length;
    logic [mbps_pkg::BYTE_W-1:0]     r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
            r_mask         <= mbps_pkg::MASK_RESET;
            r_length       <= mbps_pkg::LENGTH_RESET;
            r_key          <= mbps_pkg::KEY_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mbps_pkg::CFG_PATTERN_LOW:  r_pattern_low  <= i_cfg_wr_data;
                mbps_pkg::CFG_PATTERN_HIGH: r_pattern_high <= i_cfg_wr_data;
                mbps_pkg::CFG_COMPARE_MASK: r_mask   <= i_cfg_wr_data[mbps_pkg::MASK_W-1:0];
                mbps_pkg::CFG_PATTERN_LEN:  r_length <= i_cfg_wr_data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::CFG_XOR_KEY:      r_key    <= i_cfg_wr_data[mbps_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < mbps_pkg::HALF_BYTES; c++) begin
            o_cfg.want[c] = r_pattern_low[c*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W] ^ r_key;
            o_cfg.want[c+mbps_pkg::HALF_BYTES] =
                r_pattern_high[c*mbps_pkg::BYTE_W +: mbps_pkg::BYTE_W] ^ r_key;
        end
        o_cfg.mask = r_mask;
        // Lengths above the window depth behave as a full-depth pattern.
        if (r_length > mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN_BYTES)) begin
            o_cfg.eff_len = mbps_pkg::EFF_W'(mbps_pkg::MAX_PATTERN_BYTES);
        end else begin
            o_cfg.eff_len = mbps_pkg::EFF_W'(r_length);
        end
    end

endmodule

`default_nettype wire

>>> design/mbps_core.sv
`default_nettype none

module mbps_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic [mbps_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic                          i_last,
    input  wire mbps_pkg::t_cfg                i_cfg,
    output mbps_pkg::t_result                  o_result
);

`include "masked_byte_pattern_scanner_assert.svh"

    logic [mbps_pkg::MAX_PATTERN_BYTES-1:0][mbps_pkg::BYTE_W-1:0] r_window;
    logic [mbps_pkg::MAX_PATTERN_BYTES-1:0][mbps_pkg::BYTE_W-1:0] n_window;
    logic [mbps_pkg::COUNT_W-1:0] r_bytes_seen;
    logic [mbps_pkg::COUNT_W-1:0] n_bytes_seen;
    logic                         r_reported;

    logic [mbps_pkg::MAX_PATTERN_BYTES-1:0] lane_ok;
    logic [mbps_pkg::COUNT_W-1:0]           eff_ext;
    logic [mbps_pkg::COUNT_W-1:0]           start_off;
    logic                                   hit;

    always_comb begin
        n_window[0] = i_byte;
        for (int k = 1; k < mbps_pkg::MAX_PATTERN_BYTES; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    always_comb begin
        if (r_bytes_seen >= mbps_pkg::COUNT_W'(mbps_pkg::MAX_REGION_BYTES)) begin
            n_bytes_seen = r_bytes_seen;
        end else begin
            n_bytes_seen = r_bytes_seen + mbps_pkg::COUNT_W'(1);
        end
    end

    // Pattern byte c lines up with the window entry eff_len-1-c, counted
    // from the newest byte.
    always_comb begin
        logic [mbps_pkg::EFF_W-1:0] idx;
        for (int c = 0; c < mbps_pkg::MAX_PATTERN_BYTES; c++) begin
            idx = i_cfg.eff_len - mbps_pkg::EFF_W'(c + 1);
            if ((mbps_pkg::EFF_W'(c) < i_cfg.eff_len) && i_cfg.mask[c]) begin
                lane_ok[c] = (n_window[idx[mbps_pkg::IDX_W-1:0]] == i_cfg.want[c]);
            end else begin
                lane_ok[c] = 1'b1;
            end
        end
    end

    always_comb begin
        eff_ext = mbps_pkg::COUNT_W'(i_cfg.eff_len);
        hit     = !r_reported && (n_bytes_seen >= eff_ext) && (&lane_ok);
        // An empty pattern starts at the byte just taken.
        if (i_cfg.eff_len == '0) begin
            start_off = n_bytes_seen - mbps_pkg::COUNT_W'(1);
        end else begin
            start_off = n_bytes_seen - eff_ext;
        end
        o_result.valid  = i_fire && (hit || (i_last && !r_reported));
        o_result.found  = hit;
        o_result.offset = hit ? start_off[mbps_pkg::OFFSET_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_reported   <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_bytes_seen <= '0;
                r_reported   <= 1'b0;
            end else begin
                r_bytes_seen <= n_bytes_seen;
                if (hit) begin
                    r_reported <= 1'b1;
                end
            end
        end
    end

    `MBPS_ASSERT_SAME(a_no_second_match, r_reported, !(o_result.valid && o_result.found), "second match reported in one region")
    `MBPS_ASSERT_SAME(a_miss_only_at_end, o_result.valid && !o_result.found, i_last && i_fire, "not-found result before the region end")
    `MBPS_ASSERT_NEXT(a_clear_after_end, i_fire && i_last, (r_bytes_seen == '0) && !r_reported, "state not cleared after region end")
    `MBPS_ASSERT_SAME(a_count_saturates, 1'b1, r_bytes_seen <= mbps_pkg::COUNT_W'(mbps_pkg::MAX_REGION_BYTES), "byte count beyond region limit")

endmodule

`default_nettype wire

>>> design/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner: streams one byte per item and reports the first
// offset in each region where the keyed, masked pattern matches, or a single
// "not found" result on the region's last byte when it never matches. It takes
// one item every clock cycle while the output is not stalled; an item passes an
// input register, then the sixteen-lane window compare, and its result, if any,
// sits in the output register. Input ready drops only while both registers are
// full and the output is stalled. Configuration is written through the plain
// write port; the user must write it only while the stream is idle, as the block
// itself does not enforce this; there is no clearing pass after reset.
`default_nettype none

module masked_byte_pattern_scanner (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [mbps_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    // input bytes
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  wire logic                              s_axis_tlast,  // region_end
    // results
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output      logic [15:0]                       m_axis_tdata,  // [15:0] match_offset
    output      logic                              m_axis_tuser   // [0] found
);

    mbps_pkg::t_cfg    w_cfg;
    mbps_pkg::t_result w_result;

    logic                        r_in_valid;
    logic [mbps_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_last;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [mbps_pkg::OFFSET_W-1:0] r_out_offset;
    logic                        w_out_free;
    logic                        w_fire;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_fire;

    mbps_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (w_cfg)
    );

    mbps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.valid) begin
            r_out_found  <= w_result.found;
            r_out_offset <= w_result.offset;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_offset;
    assign m_axis_tuser  = r_out_found;

endmodule

`default_nettype wire
